### design/sma_pkg.sv
// Shared types and constants for the six-channel moving-average unit.
// Used by the tap cell, the mean lane and the top level; depends on nothing.

package sma_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int FIELD_COUNT = 6;
   localparam int DATA_W      = SAMPLE_W * FIELD_COUNT;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Stage enables handed from the top-level flow control to every lane.
   typedef struct packed {
      logic acc_en;   // input transfer: update the running sum
      logic s2_en;    // sum moves into the reciprocal multiply stage
      logic s3_en;    // estimate moves into the correction stage
   } sma_lane_ctl_type;

endpackage

### design/sma_tap_cell.sv
// One stage of the delay line: holds one sample of every channel.
// Depends on sma_pkg; chained by the top level into a window-deep row.

module sma_tap_cell #(
   parameter int CHANNELS = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    shift_en,
   input  logic [CHANNELS-1:0][sma_pkg::SAMPLE_W-1:0] tap_in,
   output logic [CHANNELS-1:0][sma_pkg::SAMPLE_W-1:0] tap_out
);
   import sma_pkg::*;

   logic [CHANNELS-1:0][SAMPLE_W-1:0] tap_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] tap_in_d;

   assign tap_in_d = shift_en ? tap_in : tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in_d;
      end
   end

   assign tap_out = tap_ff;

endmodule

### design/sma_mean_lane.sv
// Running sum and divide-by-window datapath for one channel.
// Depends on sma_pkg; the top level drives the stage enables.

module sma_mean_lane #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sma_pkg::sma_lane_ctl_type ctl,
   input  sma_pkg::sample_type       fresh,
   input  sma_pkg::sample_type       oldest,
   output sma_pkg::sample_type       mean
);
   import sma_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int MAG_W = SUM_W;
   localparam int PRD_W = 2 * MAG_W;
   // floor(2^MAG_W / WINDOW_LEN): the estimate is low by at most one.
   localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW_LEN);
   localparam logic [MAG_W-1:0] WIN_MAG = MAG_W'(WINDOW_LEN);

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [MAG_W-1:0]        mag_ff;
   logic [MAG_W-1:0]        mag_in;
   logic                    neg_ff;
   logic                    neg_in;
   logic [SAMPLE_W-1:0]     q_est_ff;
   logic [SAMPLE_W-1:0]     q_est_in;
   logic [SAMPLE_W-1:0]     mean_ff;
   logic [SAMPLE_W-1:0]     mean_in;
   logic [PRD_W-1:0]        product;
   logic [MAG_W-1:0]        sum_bits;
   logic [MAG_W-1:0]        q_times_w;
   logic [MAG_W-1:0]        remainder;
   logic [SAMPLE_W-1:0]     q_fix;

   // The wrapped sum is exact because the true window sum always fits.
   assign sum_in = sum_ff + SUM_W'(fresh) - SUM_W'(oldest);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.acc_en) begin
         sum_ff <= sum_in;
      end
   end

   // Divide the magnitude, then restore the sign: truncation toward zero.
   assign sum_bits = $unsigned(sum_ff);
   assign neg_in   = sum_ff[SUM_W-1];
   assign mag_in   = neg_in ? (~sum_bits + 1'b1) : sum_bits;
   assign product  = PRD_W'(mag_in) * PRD_W'(RECIP);
   assign q_est_in = product[MAG_W +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         q_est_ff <= q_est_in;
      end
   end

   assign q_times_w = MAG_W'(MAG_W'(q_est_ff) * WIN_MAG);
   assign remainder = mag_ff - q_times_w;
   assign q_fix     = (remainder >= WIN_MAG) ? (q_est_ff + 1'b1) : q_est_ff;
   assign mean_in   = neg_ff ? (~q_fix + 1'b1) : q_fix;

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         mean_ff <= mean_in;
      end
   end

   assign mean = $signed(mean_ff);

endmodule

### design/six_channel_moving_average_unit.sv
// Top level of the six-channel moving-average unit.
// Depends on sma_pkg, sma_tap_cell and sma_mean_lane.
//
// Usage:
//   req_ carries one sensor sample set per transfer: six signed 16-bit
//   samples (accelerometer x/y/z, gyroscope x/y/z). rsp_ returns one result
//   per input: the six window means, each the sum of the last WINDOW_LEN
//   samples of its channel divided by WINDOW_LEN, truncated toward zero.
//   The delay line is a row of WINDOW_LEN tap cells that shift on every
//   input transfer; the cell at the end supplies the sample leaving the
//   window, and a running sum per channel is updated with it.
//   Pipeline: an input transfer passes the running-sum stage, the reciprocal
//   multiply stage and the remainder correction and sign restore stage in
//   order; rsp_tvalid rises once the last of them holds the result.
//   Throughput: one item per cycle while req_tready is high; the three-stage
//   pipeline keeps accepting while a result waits, until all three are full.
//   Reset: all taps and sums clear to zero, so the first WINDOW_LEN-1
//   results average in zeros; the pipeline empties.
//   Stall: when rsp_tready is low the result holds, the pipeline fills its
//   empty stages, and req_tready falls once all three stages are full.
//   Channels at or beyond CHANNELS return zero.

module six_channel_moving_average_unit #(
   parameter int WINDOW_LEN = 10,
   parameter int CHANNELS   = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
   input  logic [sma_pkg::DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // mean_accel_x, mean_accel_y, mean_accel_z,
   // mean_gyro_x, mean_gyro_y, mean_gyro_z (16 bits each)
   output logic [sma_pkg::DATA_W-1:0] rsp_tdata
);
   import sma_pkg::*;

   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;
   logic accept, adv1, adv2;
   sma_lane_ctl_type lane_ctl;

   logic [CHANNELS-1:0][SAMPLE_W-1:0] taps [0:WINDOW_LEN];
   sample_type                        means [0:FIELD_COUNT-1];

   // Per-stage flow control: a stage takes data when empty or draining.
   assign rdy3   = !v3_ff || rsp_tready;
   assign rdy2   = !v2_ff || rdy3;
   assign rdy1   = !v1_ff || rdy2;
   assign accept = req_tvalid && rdy1;
   assign adv1   = v1_ff && rdy2;
   assign adv2   = v2_ff && rdy3;

   assign v1_in = accept || (v1_ff && !rdy2);
   assign v2_in = adv1 || (v2_ff && !rdy3);
   assign v3_in = adv2 || (v3_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign lane_ctl.acc_en = accept;
   assign lane_ctl.s2_en  = adv1;
   assign lane_ctl.s3_en  = adv2;

   genvar c, k;
   generate
      for (c = 0; c < CHANNELS; c++) begin : g_in
         assign taps[0][c] = req_tdata[c*SAMPLE_W +: SAMPLE_W];
      end

      for (k = 0; k < WINDOW_LEN; k++) begin : g_tap
         sma_tap_cell #(
            .CHANNELS(CHANNELS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(accept),
            .tap_in  (taps[k]),
            .tap_out (taps[k+1])
         );
      end

      for (c = 0; c < FIELD_COUNT; c++) begin : g_lane
         if (c < CHANNELS) begin : g_used
            sma_mean_lane #(
               .WINDOW_LEN(WINDOW_LEN)
            ) u_lane (
               .clock (clock),
               .reset (reset),
               .ctl   (lane_ctl),
               .fresh ($signed(taps[0][c])),
               .oldest($signed(taps[WINDOW_LEN][c])),
               .mean  (means[c])
            );
         end else begin : g_unused
            assign means[c] = '0;
         end
         assign rsp_tdata[c*SAMPLE_W +: SAMPLE_W] = means[c];
      end
   endgenerate

   assign req_tready = rdy1;
   assign rsp_tvalid = v3_ff;

   // An input transfer always lands in the running-sum stage.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted item did not reach the sum stage");

   // A result leaving the multiply stage always becomes visible next cycle.
   a_adv_to_out: assert property (@(posedge clock) disable iff (reset)
      adv2 |=> rsp_tvalid)
      else $error("result lost between multiply and output stage");

   // An empty pipeline never refuses input.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !v3_ff) |-> req_tready)
      else $error("empty pipeline refused input");

   // Reset empties every stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");

endmodule
